[design/sma_pkg.sv]
// sma_pkg: shared constants for the simple moving average block.
// Sizes of the sample path, the running sum and the serial divider.
// No dependencies.
`timescale 1ns / 1ps

package sma_pkg;

   // Window and sample geometry
   localparam int WINDOW_MAX   = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int FRAC_BITS    = 8;
   localparam int LEN_WIDTH    = 7;
   localparam int POS_WIDTH    = $clog2(WINDOW_MAX);

   // Running sum holds WINDOW_MAX samples without overflow
   localparam int SUM_WIDTH    = SAMPLE_WIDTH + POS_WIDTH;
   localparam int MEAN_WIDTH   = 40;

   // Serial divider: one quotient bit per cycle
   localparam int DIV_WIDTH    = SUM_WIDTH + FRAC_BITS;
   localparam int CNT_WIDTH    = $clog2(DIV_WIDTH);

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_LEN    = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRUNCATE_MODE = 1'd1;

endpackage

[design/simple_moving_average.sv]
// simple_moving_average: windowed mean with ring store and bit-serial divider; uses sma_pkg.
// A sample that completes a window has its mean after sum update, divider load, 46 divide
// steps and output load; other samples free the block after the sum update. New samples
// are stalled until a producing sample's mean is loaded into the output register.
// Reset (synchronous): window empty, window_len 1, fractional mode, no result held.
`timescale 1ns / 1ps

module simple_moving_average (
   input  logic                                     clock,
   input  logic                                     reset,
   // sample channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [sma_pkg::SAMPLE_WIDTH-1:0]  req_sample,
   input  logic                                     req_start_series,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [sma_pkg::MEAN_WIDTH-1:0]    rsp_mean_value,
   // configuration writes
   input  logic                                     csr_write_en,
   input  logic [sma_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [sma_pkg::LEN_WIDTH-1:0]            csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [sma_pkg::LEN_WIDTH-1:0] len_ff;
   logic                          trunc_ff;
   logic [sma_pkg::LEN_WIDTH-1:0] len_eff;

   // window state
   logic signed [sma_pkg::SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic [sma_pkg::POS_WIDTH-1:0]           wpos_ff, wpos_in;
   logic [sma_pkg::LEN_WIDTH-1:0]           fill_ff, fill_in;
   logic [sma_pkg::SAMPLE_WIDTH-1:0]        window_mem [sma_pkg::WINDOW_MAX];
   logic signed [sma_pkg::SAMPLE_WIDTH-1:0] old_sample_ff;
   logic signed [sma_pkg::SAMPLE_WIDTH-1:0] sample_ff;
   logic                                    full_ff, full_in;
   logic                                    produce_ff, produce_in;

   // divider
   logic [sma_pkg::DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [sma_pkg::LEN_WIDTH-1:0] rem_ff, rem_in;
   logic [sma_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                          neg_ff, neg_in;

   // output register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [sma_pkg::MEAN_WIDTH-1:0] rsp_mean_ff, rsp_mean_in;

   // scratch
   logic                              accept;
   logic                              cfg_len_wr;
   logic [sma_pkg::POS_WIDTH-1:0]     pos_base, pos;
   logic [sma_pkg::LEN_WIDTH-1:0]     pos_next, fill_base;
   logic [sma_pkg::SUM_WIDTH-1:0]     mag;
   logic [sma_pkg::LEN_WIDTH:0]       trial;
   logic [sma_pkg::MEAN_WIDTH-1:0]    q_low;

   // Effective window length: zero acts as one, large values clamp
   always_comb begin
      if (len_ff == '0) begin
         len_eff = sma_pkg::LEN_WIDTH'(1);
      end else if (len_ff > sma_pkg::LEN_WIDTH'(sma_pkg::WINDOW_MAX)) begin
         len_eff = sma_pkg::LEN_WIDTH'(sma_pkg::WINDOW_MAX);
      end else begin
         len_eff = len_ff;
      end
   end

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign cfg_len_wr = csr_write_en && (csr_index == sma_pkg::CSR_WINDOW_LEN);

   // Ring position and fill level for the incoming beat
   always_comb begin
      pos_base  = req_start_series ? '0 : wpos_ff;
      pos       = ({1'b0, pos_base} >= len_eff) ? '0 : pos_base;
      pos_next  = {1'b0, pos} + sma_pkg::LEN_WIDTH'(1);
      fill_base = req_start_series ? '0 : fill_ff;
      full_in   = (fill_base >= len_eff);
      fill_in   = full_in ? len_eff : fill_base + sma_pkg::LEN_WIDTH'(1);
      produce_in = (fill_in >= len_eff);
      wpos_in   = (pos_next >= len_eff) ? '0 : pos_next[sma_pkg::POS_WIDTH-1:0];
   end

   // Ring store: old entry read out as the new one goes in
   always_ff @(posedge clock) begin
      if (accept) begin
         window_mem[pos] <= req_sample;
         old_sample_ff   <= window_mem[pos];
      end
   end

   // Divider step and result formatting
   always_comb begin
      mag   = sum_ff[sma_pkg::SUM_WIDTH-1] ? -sum_ff : sum_ff;
      trial = {rem_ff, quo_ff[sma_pkg::DIV_WIDTH-1]};
      q_low = neg_ff ? -quo_ff[sma_pkg::MEAN_WIDTH-1:0] : quo_ff[sma_pkg::MEAN_WIDTH-1:0];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mean_in  = rsp_mean_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_start_series) begin
                  sum_in = '0;
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            sum_in = sum_ff
                   + sma_pkg::SUM_WIDTH'(sample_ff)
                   - (full_ff ? sma_pkg::SUM_WIDTH'(old_sample_ff) : '0);
            state_in = produce_ff ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            neg_in = sum_ff[sma_pkg::SUM_WIDTH-1];
            if (trunc_ff) begin
               quo_in = sma_pkg::DIV_WIDTH'(mag);
            end else begin
               quo_in = {mag, sma_pkg::FRAC_BITS'(0)};
            end
            rem_in   = '0;
            cnt_in   = sma_pkg::CNT_WIDTH'(sma_pkg::DIV_WIDTH - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // restoring step: one quotient bit per cycle
            if (trial >= {1'b0, len_eff}) begin
               rem_in = sma_pkg::LEN_WIDTH'(trial - {1'b0, len_eff});
               quo_in = {quo_ff[sma_pkg::DIV_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = trial[sma_pkg::LEN_WIDTH-1:0];
               quo_in = {quo_ff[sma_pkg::DIV_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff - sma_pkg::CNT_WIDTH'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = q_low;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // window_len write empties the window
      if (cfg_len_wr) begin
         sum_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= sma_pkg::LEN_WIDTH'(1);
         trunc_ff     <= 1'b0;
         sum_ff       <= '0;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         // window_len write empties the window
         if (cfg_len_wr) begin
            wpos_ff <= '0;
            fill_ff <= '0;
         end else if (accept) begin
            wpos_ff <= wpos_in;
            fill_ff <= fill_in;
         end
         if (csr_write_en) begin
            case (csr_index)
               sma_pkg::CSR_WINDOW_LEN: begin
                  len_ff  <= csr_wdata;
               end
               sma_pkg::CSR_TRUNCATE_MODE: begin
                  trunc_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      rsp_mean_ff <= rsp_mean_in;
      if (accept) begin
         sample_ff  <= req_sample;
         full_ff    <= full_in;
         produce_ff <= produce_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_value = rsp_mean_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_eff)
      else $error("fill level beyond window length");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wpos_ff} < len_eff)
      else $error("ring position outside window");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < len_eff))
      else $error("divider remainder not below divisor");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result beat raised outside finish step");

endmodule

[tb/sv/tb_simple_moving_average.sv]
// tb_simple_moving_average: self-checking testbench for the moving average block.
// Drives sample beats and CSR writes, predicts every window mean, checks rsp beats.
// Depends on sma_pkg and simple_moving_average.
`timescale 1ns / 1ps

module tb_simple_moving_average;

   typedef struct packed {
      logic signed [sma_pkg::SAMPLE_WIDTH-1:0] sample;
      logic                                    restart;
   } sample_beat_type;

   // DUT connections, the inputs at known values from time zero
   logic                                       clock            = 1'b0;
   logic                                       reset            = 1'b1;
   logic                                       req_valid        = 1'b0;
   logic                                       req_stall;
   logic signed [sma_pkg::SAMPLE_WIDTH-1:0]    req_sample       = '0;
   logic                                       req_start_series = 1'b0;
   logic                                       rsp_valid;
   logic                                       rsp_stall        = 1'b0;
   logic signed [sma_pkg::MEAN_WIDTH-1:0]      rsp_mean_value;
   logic                                       csr_write_en     = 1'b0;
   logic [sma_pkg::CSR_INDEX_WIDTH-1:0]        csr_index        = '0;
   logic [sma_pkg::LEN_WIDTH-1:0]              csr_wdata        = '0;

   // Traffic control
   sample_beat_type                            sample_backlog[$];
   sample_beat_type                            next_beat;
   logic signed [sma_pkg::MEAN_WIDTH-1:0]      expected_means[$];
   logic signed [sma_pkg::MEAN_WIDTH-1:0]      want_mean;
   int unsigned                                send_idle_pct = 23;
   int unsigned                                recv_idle_pct = 48;
   bit                                         req_beat      = 1'b0;
   bit                                         hold_go       = 1'b0;
   logic                                       rsp_hold      = 1'b0;
   int unsigned                                mismatches    = 0;

   // Window predictor state
   logic signed [sma_pkg::SAMPLE_WIDTH-1:0]    win_store[sma_pkg::WINDOW_MAX];
   longint                                     win_sum;
   int unsigned                                win_pos;
   int unsigned                                win_fill;
   logic [sma_pkg::LEN_WIDTH-1:0]              cfg_len;
   bit                                         cfg_trunc;

   simple_moving_average u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_start_series (req_start_series),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean_value   (rsp_mean_value),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin : clock_gen
      forever #10 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      if (mismatches < 200) $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic clear_window;
      win_sum  = 0;
      win_pos  = 0;
      win_fill = 0;
   endtask

   // Take one sample into the window; queue the mean once the window is full
   task automatic advance_window(input logic signed [sma_pkg::SAMPLE_WIDTH-1:0] smp,
                                 input logic restart);
      longint eff;
      longint mean;
      eff = (cfg_len == 0) ? 1 : ((cfg_len > sma_pkg::WINDOW_MAX) ? sma_pkg::WINDOW_MAX
                                                                    : cfg_len);
      if (restart) clear_window();
      if (win_pos >= eff) win_pos = 0;
      if (win_fill >= eff) begin
         win_sum  = win_sum - win_store[win_pos];
         win_fill = eff;
      end else begin
         win_fill++;
      end
      win_store[win_pos] = smp;
      win_sum = win_sum + smp;
      win_pos++;
      if (win_pos >= eff) win_pos = 0;
      if (win_fill >= eff) begin
         if (cfg_trunc) mean = win_sum / eff;
         else mean = (win_sum * (longint'(1) <<< sma_pkg::FRAC_BITS)) / eff;
         expected_means.insert(expected_means.size(), mean[sma_pkg::MEAN_WIDTH-1:0]);
      end
   endtask

   // Predictor and result checker, sampled at the rising edge
   always @(posedge clock) begin : mean_checker
      if (reset) begin
         cfg_len   = sma_pkg::LEN_WIDTH'(1);
         cfg_trunc = 1'b0;
         req_beat  = 1'b0;
         clear_window();
      end else begin
         req_beat = req_valid && !req_stall;
         if (req_beat) advance_window(req_sample, req_start_series);
         if (csr_write_en) begin
            if (csr_index == sma_pkg::CSR_WINDOW_LEN) begin
               cfg_len = csr_wdata;
               clear_window();
            end else if (csr_index == sma_pkg::CSR_TRUNCATE_MODE) begin
               cfg_trunc = csr_wdata[0];
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_means.size() == 0) begin
               flag_mismatch($sformatf("mean %0d with none expected", rsp_mean_value));
            end else begin
               want_mean = expected_means.pop_front();
               if (rsp_mean_value !== want_mean)
                  flag_mismatch($sformatf("mean_value got %0d, want %0d",
                                          rsp_mean_value, want_mean));
            end
         end
      end
   end

   // Sample driver: next beat once the current one is taken or none is up
   always @(negedge clock) begin : sample_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat) begin
         if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_beat = sample_backlog.pop_front();
            req_valid        <= 1'b1;
            req_sample       <= next_beat.sample;
            req_start_series <= next_beat.restart;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin : rsp_staller
      if (rsp_hold) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // One long hold-off on the result side so the block backs up its input
   initial begin : rsp_hold_off
      int unsigned held;
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      for (held = 0; held < 500; held++) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic offer(input logic signed [sma_pkg::SAMPLE_WIDTH-1:0] smp,
                        input logic restart);
      sample_backlog.insert(sample_backlog.size(), sample_beat_type'{smp, restart});
   endtask

   task automatic write_csr(input logic [sma_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [sma_pkg::LEN_WIDTH-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Block is idle once all beats are out and all means are back
   task automatic wait_idle;
      do @(posedge clock);
      while (expected_means.size() != 0 || sample_backlog.size() != 0 || req_valid);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic signed [sma_pkg::SAMPLE_WIDTH-1:0] pick_sample(
      input int unsigned flavor);
      case (flavor)
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         2: return 32'($urandom_range(200)) - 32'd100;
         default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(15)
                                           : 32'h8000_0000 + $urandom_range(15);
      endcase
   endfunction

   initial begin : stimulus
      int unsigned                   random_items;
      int unsigned                   n_series;
      int unsigned                   s;
      int unsigned                   k;
      int unsigned                   ser_len;
      int unsigned                   flavor;
      int unsigned                   eff;
      int unsigned                   pick;
      logic [sma_pkg::LEN_WIDTH-1:0] cur_len;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: window of one, fractional mean
      offer(32'sh7fff_ffff, 1'b1);
      offer(32'sh8000_0000, 1'b0);
      offer(32'sd0, 1'b0);
      offer(-32'sd1, 1'b0);
      wait_idle();

      // Window of three, integer mean; negative sums truncate toward zero
      write_csr(sma_pkg::CSR_WINDOW_LEN, 7'd3);
      write_csr(sma_pkg::CSR_TRUNCATE_MODE, 7'd1);
      @(posedge clock);
      offer(-32'sd1, 1'b1);
      offer(-32'sd1, 1'b0);
      offer(-32'sd2, 1'b0);
      offer(32'sd7, 1'b0);
      offer(32'sd5, 1'b1);       // new series mid-stream
      offer(32'sd6, 1'b0);
      offer(32'sd7, 1'b0);
      wait_idle();

      // Mode switch keeps the window
      write_csr(sma_pkg::CSR_TRUNCATE_MODE, 7'd0);
      @(posedge clock);
      offer(32'sd9, 1'b0);
      wait_idle();

      // Zero length acts as one
      write_csr(sma_pkg::CSR_WINDOW_LEN, 7'd0);
      @(posedge clock);
      offer(-32'sd3, 1'b0);
      offer(32'sh8000_0000, 1'b0);
      wait_idle();

      // Sum wider than a sample; rewriting the same length empties the window
      write_csr(sma_pkg::CSR_WINDOW_LEN, 7'd2);
      @(posedge clock);
      offer(32'sh7fff_ffff, 1'b0);
      offer(32'sh7fff_ffff, 1'b0);
      wait_idle();
      write_csr(sma_pkg::CSR_WINDOW_LEN, 7'd2);
      @(posedge clock);
      offer(32'sh8000_0000, 1'b0);
      offer(32'sh8000_0000, 1'b0);
      wait_idle();

      // Long result-side hold-off with the sender still offering
      write_csr(sma_pkg::CSR_WINDOW_LEN, 7'd1);
      cur_len = 7'd1;
      @(posedge clock);
      hold_go = 1'b1;
      for (k = 0; k < 40; k++) offer(pick_sample(0), 1'b0);
      random_items = 40;

      // Random phases of well-formed series with some noise
      while (random_items < 950) begin
         wait_idle();
         if (random_items < 317) begin
            send_idle_pct = 23;
            recv_idle_pct = 48;
         end else if (random_items < 634) begin
            send_idle_pct = 48;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if ($urandom_range(99) < 80) begin
            pick = $urandom_range(99);
            if (pick < 45) cur_len = sma_pkg::LEN_WIDTH'($urandom_range(8, 1));
            else if (pick < 70) cur_len = sma_pkg::LEN_WIDTH'($urandom_range(32, 9));
            else if (pick < 80) cur_len = sma_pkg::LEN_WIDTH'($urandom_range(63, 33));
            else if (pick < 88) cur_len = 7'd64;
            else if (pick < 94) cur_len = sma_pkg::LEN_WIDTH'($urandom_range(126, 65));
            else if (pick < 97) cur_len = 7'd0;
            else cur_len = 7'd127;
            write_csr(sma_pkg::CSR_WINDOW_LEN, cur_len);
         end
         if ($urandom_range(99) < 70)
            write_csr(sma_pkg::CSR_TRUNCATE_MODE, 7'($urandom_range(127)));
         @(posedge clock);
         eff = (cur_len == 0) ? 1 : ((cur_len > sma_pkg::WINDOW_MAX) ? sma_pkg::WINDOW_MAX
                                                                      : cur_len);
         n_series = $urandom_range(3, 1);
         for (s = 0; s < n_series; s++) begin
            flavor  = $urandom_range(3);
            // mostly full series, now and then one cut short
            ser_len = ($urandom_range(9) == 0) ? $urandom_range(eff, 1)
                                               : eff + $urandom_range(24);
            for (k = 0; k < ser_len; k++)
               offer(pick_sample(flavor), (k == 0) ? ($urandom_range(9) != 0)
                                                   : ($urandom_range(19) == 0));
            random_items += ser_len;
         end
      end

      // Drain, then let the divider settle
      wait_idle();
      repeat (60) @(posedge clock);
      if (expected_means.size() != 0)
         flag_mismatch($sformatf("%0d means never arrived", expected_means.size()));
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #(20_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
design/sma_pkg.sv
design/simple_moving_average.sv
tb/sv/tb_simple_moving_average.sv
